FILE: rtl/core/pfr_pkg.sv
package pfr_pkg;

    localparam int NUM_STATES_DEF = 8;

    localparam logic [2:0] REQ_STEP     = 3'd0;
    localparam logic [2:0] REQ_REDIRECT = 3'd1;
    localparam logic [2:0] REQ_QUERY    = 3'd2;
    localparam logic [2:0] REQ_DEL_ALL  = 3'd3;
    localparam logic [2:0] REQ_DEL_ONE  = 3'd4;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_DELETED   = 2'd1;
    localparam logic [1:0] ST_REACHABLE = 2'd2;

    typedef logic [2:0] reset_tab_t [8];

    localparam reset_tab_t RESET_ZERO = '{3'd4, 3'd5, 3'd2, 3'd2, 3'd5, 3'd3, 3'd7, 3'd6};
    localparam reset_tab_t RESET_ONE  = '{3'd7, 3'd4, 3'd1, 3'd0, 3'd6, 3'd0, 3'd2, 3'd3};

    typedef enum logic [2:0] {
        OP_STEP,
        OP_REDIR,
        OP_QUERY,
        OP_DELALL,
        OP_DELONE,
        OP_REJECT
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic       in_bit;
        logic [2:0] target;
    } op_t;

    typedef struct packed {
        logic [2:0] current_state;
        logic [7:0] unreachable_mask;
        logic [7:0] present_mask;
        logic [1:0] status;
    } result_t;

endpackage

FILE: rtl/core/programmable_fsm_with_reachability_core.sv
// Channel  Dir  Ports                 Beat contents
// s_       in   s_tvalid/tready/data  tdata: in_bit, target_state; tuser: req_type
// m_       out  m_tvalid/tready/data  tdata: current_state, unreachable_mask,
//                                     present_mask, status
// In the back end a step passes through S_STEP first, and every request runs a reachability search
// of P table sweeps (1 to NUM_STATES), repeated until the reachable set stops growing.
// The front register and the two-beat queue keep accepting while a request is being worked on
// or a result waits for m_tready, until both are full.
// Reset is synchronous on aresetn low and restores the reset table through per-entry valid bits.
module programmable_fsm_with_reachability_core
    import pfr_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [0] in_bit, [3:1] target_state, [7:4] zero
    input  logic [2:0]  s_tuser,  // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // [2:0] current_state, [10:3] unreachable_mask,
                                  // [18:11] present_mask, [20:19] status, [23:21] zero
);

    logic    op_valid;
    logic    op_ready;
    op_t     front_op;
    logic    q_valid;
    logic    q_pop;
    op_t     q_op;
    result_t res;

    pfr_front #(
        .NUM_STATES(NUM_STATES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .op_valid(op_valid),
        .op_ready(op_ready),
        .op      (front_op)
    );

    pfr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (op_valid),
        .in_ready (op_ready),
        .in_op    (front_op),
        .out_valid(q_valid),
        .out_ready(q_pop),
        .out_op   (q_op)
    );

    pfr_back #(
        .NUM_STATES(NUM_STATES)
    ) u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_valid(q_valid),
        .q_pop  (q_pop),
        .q_op   (q_op),
        .m_valid(m_tvalid),
        .m_ready(m_tready),
        .res    (res)
    );

    assign m_tdata = {3'b000, res.status, res.present_mask, res.unreachable_mask,
                      res.current_state};

endmodule

FILE: rtl/core/pfr_front.sv
module pfr_front
    import pfr_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [2:0] s_tuser,
    output logic       op_valid,
    input  logic       op_ready,
    output op_t        op
);

    localparam logic [6:0] NS_LIMIT = 7'(NUM_STATES);

    logic       op_valid_reg;
    logic       op_valid_next;
    op_t        op_reg;
    op_t        op_next;
    logic       tgt_ok;
    logic [2:0] req;

    assign req      = s_tuser;
    assign tgt_ok   = {4'b0000, s_tdata[3:1]} < NS_LIMIT;
    assign s_tready = !op_valid_reg || op_ready;
    assign op_valid = op_valid_reg;
    assign op       = op_reg;

    always_comb begin
        op_next        = op_reg;
        op_valid_next  = op_valid_reg;
        if (op_valid_reg && op_ready) begin
            op_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            op_valid_next  = 1'b1;
            op_next.in_bit = s_tdata[0];
            op_next.target = s_tdata[3:1];
            case (req)
                REQ_STEP:     op_next.kind = OP_STEP;
                REQ_REDIRECT: op_next.kind = tgt_ok ? OP_REDIR : OP_REJECT;
                REQ_QUERY:    op_next.kind = OP_QUERY;
                REQ_DEL_ALL:  op_next.kind = OP_DELALL;
                REQ_DEL_ONE:  op_next.kind = tgt_ok ? OP_DELONE : OP_QUERY;
                default:      op_next.kind = OP_QUERY;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg <= 1'b0;
        end else begin
            op_valid_reg <= op_valid_next;
        end
        op_reg <= op_next;
    end

endmodule

FILE: rtl/core/pfr_queue.sv
module pfr_queue
    import pfr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  op_t  in_op,
    output logic out_valid,
    input  logic out_ready,
    output op_t  out_op
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    op_t           entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          push;
    logic          pop;

    assign in_ready  = count_reg != (PW+1)'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_op    = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

FILE: rtl/core/pfr_back.sv
module pfr_back
    import pfr_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    output logic    q_pop,
    input  op_t     q_op,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t res
);

    localparam int                    SW        = $clog2(NUM_STATES);
    localparam logic [SW-1:0]         LAST      = SW'(NUM_STATES - 1);
    localparam logic [SW-1:0]         CUR_RESET = SW'(3 % NUM_STATES);
    localparam logic [NUM_STATES-1:0] ONE_N     = NUM_STATES'(1);
    localparam logic [NUM_STATES-1:0] FULL      = {NUM_STATES{1'b1}};

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_STEP   = 6'b000100,
        S_INIT   = 6'b001000,
        S_RUN    = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    typedef enum logic [0:0] {
        P_SWEEP = 1'b0,
        P_TAIL  = 1'b1
    } phase_t;

    logic [SW-1:0]         mem0 [NUM_STATES];
    logic [SW-1:0]         mem1 [NUM_STATES];
    logic [SW-1:0]         dflt0 [NUM_STATES];
    logic [SW-1:0]         dflt1 [NUM_STATES];

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    op_t                   op_reg, op_next;
    logic [SW-1:0]         cur_reg, cur_next;
    logic [NUM_STATES-1:0] alive_reg, alive_next;
    logic [NUM_STATES-1:0] reach_reg, reach_next;
    logic [NUM_STATES-1:0] val0_reg, val0_next;
    logic [NUM_STATES-1:0] val1_reg, val1_next;
    logic                  changed_reg, changed_next;
    logic [SW-1:0]         idx_reg, idx_next;
    logic                  rdv_reg, rdv_next;
    logic [1:0]            status_reg, status_next;
    logic                  m_valid_reg, m_valid_next;
    result_t               res_reg, res_next;

    logic [SW-1:0]         rd_addr;
    logic [SW-1:0]         rd0_reg, rd1_reg, addr_reg;
    logic                  rv0_reg, rv1_reg;
    logic [SW-1:0]         n0, n1;
    logic [NUM_STATES-1:0] succ, upd, unreach, alive_new;
    logic                  grow;
    logic                  wr0, wr1;
    logic [SW+2:0]         tgt_ext, cur_ext;
    logic [SW-1:0]         tgt_idx;
    logic [NUM_STATES+7:0] unreach_ext, alive_ext;
    logic [1:0]            fin_status;

    for (genvar s = 0; s < NUM_STATES; s++) begin : g_dflt
        if (s < 8) begin : g_tab
            localparam int Z = int'(RESET_ZERO[s]);
            localparam int O = int'(RESET_ONE[s]);
            assign dflt0[s] = SW'(Z % NUM_STATES);
            assign dflt1[s] = SW'(O % NUM_STATES);
        end else begin : g_self
            assign dflt0[s] = SW'(s);
            assign dflt1[s] = SW'(s);
        end
    end

    assign tgt_ext = (SW+3)'(op_reg.target);
    assign tgt_idx = tgt_ext[SW-1:0];
    assign n0      = rv0_reg ? rd0_reg : dflt0[addr_reg];
    assign n1      = rv1_reg ? rd1_reg : dflt1[addr_reg];
    assign succ    = (ONE_N << n0) | (ONE_N << n1);
    assign upd     = reach_reg | ((rdv_reg && reach_reg[addr_reg]) ? succ : '0);
    assign grow    = upd != reach_reg;
    assign unreach = ~reach_reg & FULL;
    assign m_valid = m_valid_reg;
    assign res     = res_reg;

    always_comb begin
        alive_new  = alive_reg;
        fin_status = status_reg;
        case (op_reg.kind)
            OP_DELALL: alive_new = alive_reg & reach_reg;
            OP_DELONE: begin
                if (reach_reg[tgt_idx]) begin
                    fin_status = ST_REACHABLE;
                end else begin
                    alive_new = alive_reg & ~(ONE_N << tgt_idx);
                end
            end
            default: alive_new = alive_reg;
        endcase
    end

    assign cur_ext     = (SW+3)'(cur_reg);
    assign unreach_ext = (NUM_STATES+8)'(unreach);
    assign alive_ext   = (NUM_STATES+8)'(alive_new);

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        op_next      = op_reg;
        cur_next     = cur_reg;
        alive_next   = alive_reg;
        reach_next   = upd;
        val0_next    = val0_reg;
        val1_next    = val1_reg;
        changed_next = changed_reg;
        idx_next     = idx_reg;
        rdv_next     = 1'b0;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        res_next     = res_reg;
        rd_addr      = idx_reg;
        q_pop        = 1'b0;
        wr0          = 1'b0;
        wr1          = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    op_next    = q_op;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                rd_addr     = cur_reg;
                status_next = ST_DONE;
                state_next  = S_INIT;
                case (op_reg.kind)
                    OP_STEP: state_next = S_STEP;
                    OP_REDIR: begin
                        if (alive_reg[tgt_idx]) begin
                            wr1 = op_reg.in_bit;
                            wr0 = !op_reg.in_bit;
                        end else begin
                            status_next = ST_DELETED;
                        end
                    end
                    OP_REJECT: status_next = ST_DELETED;
                    default: status_next = ST_DONE;
                endcase
                if (wr0) begin
                    val0_next = val0_reg | (ONE_N << cur_reg);
                end
                if (wr1) begin
                    val1_next = val1_reg | (ONE_N << cur_reg);
                end
            end
            S_STEP: begin
                cur_next   = op_reg.in_bit ? n1 : n0;
                state_next = S_INIT;
            end
            S_INIT: begin
                reach_next   = ONE_N << cur_reg;
                idx_next     = '0;
                changed_next = 1'b0;
                phase_next   = P_SWEEP;
                state_next   = S_RUN;
            end
            S_RUN: begin
                changed_next = changed_reg | grow;
                case (phase_reg)
                    P_SWEEP: begin
                        rdv_next = 1'b1;
                        if (idx_reg == LAST) begin
                            phase_next = P_TAIL;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    P_TAIL: begin
                        if (changed_reg || grow) begin
                            changed_next = 1'b0;
                            idx_next     = '0;
                            phase_next   = P_SWEEP;
                        end else begin
                            state_next = S_FINISH;
                        end
                    end
                    default: phase_next = P_SWEEP;
                endcase
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    alive_next                = alive_new;
                    res_next.current_state    = cur_ext[2:0];
                    res_next.unreachable_mask = unreach_ext[7:0];
                    res_next.present_mask     = alive_ext[7:0];
                    res_next.status           = fin_status;
                    m_valid_next              = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        rd0_reg  <= mem0[rd_addr];
        rd1_reg  <= mem1[rd_addr];
        rv0_reg  <= val0_reg[rd_addr];
        rv1_reg  <= val1_reg[rd_addr];
        addr_reg <= rd_addr;
        if (wr0) begin
            mem0[cur_reg] <= tgt_idx;
        end
        if (wr1) begin
            mem1[cur_reg] <= tgt_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= P_SWEEP;
            cur_reg     <= CUR_RESET;
            alive_reg   <= FULL;
            val0_reg    <= '0;
            val1_reg    <= '0;
            changed_reg <= 1'b0;
            idx_reg     <= '0;
            rdv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cur_reg     <= cur_next;
            alive_reg   <= alive_next;
            val0_reg    <= val0_next;
            val1_reg    <= val1_next;
            changed_reg <= changed_next;
            idx_reg     <= idx_next;
            rdv_reg     <= rdv_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        reach_reg  <= reach_next;
        status_reg <= status_next;
        res_reg    <= res_next;
    end

    a_finish_reach: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH) |-> reach_reg[cur_reg])
        else $error("Reachable set lost the current state.");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("Finished result was not presented.");

    a_tail_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN && phase_reg == P_TAIL) |-> rdv_reg)
        else $error("Sweep tail has no pending table read.");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pfr_pkg::*;

    localparam int RANDOM_ITEMS  = 1330;
    localparam int QUIET_ITEMS   = 250;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 200;

    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;
    localparam logic [2:0] START_STATE     = 3'd3;

    class fsm_scoreboard;
        logic [2:0] zero_tab [8];
        logic [2:0] one_tab [8];
        logic [2:0] cur;
        logic [7:0] alive;
        result_t    pending [$];
        int         errors;

        function new();
            for (int s = 0; s < 8; s++) begin
                zero_tab[s] = RESET_ZERO[s];
                one_tab[s]  = RESET_ONE[s];
            end
            cur    = START_STATE;
            alive  = '1;
            errors = 0;
        endfunction

        // Successor sets are OR-ed in over eight passes, enough for the set to stop growing.
        function logic [7:0] reach_set();
            logic [7:0] r;
            logic [7:0] nx;
            r = 8'd1 << cur;
            for (int it = 0; it < 8; it++) begin
                nx = r;
                for (int s = 0; s < 8; s++) begin
                    if (r[s]) begin
                        nx[zero_tab[s]] = 1'b1;
                        nx[one_tab[s]]  = 1'b1;
                    end
                end
                r = nx;
            end
            return r;
        endfunction

        function void note_request(logic [2:0] req, logic sym, logic [2:0] tgt);
            result_t    r;
            logic [1:0] st;
            logic [7:0] reach;
            st = ST_DONE;
            case (req)
                REQ_STEP: begin
                    cur = sym ? one_tab[cur] : zero_tab[cur];
                end
                REQ_REDIRECT: begin
                    if (!alive[tgt]) begin
                        st = ST_DELETED;
                    end else if (sym) begin
                        one_tab[cur] = tgt;
                    end else begin
                        zero_tab[cur] = tgt;
                    end
                end
                REQ_DEL_ALL: begin
                    alive &= reach_set();
                end
                REQ_DEL_ONE: begin
                    reach = reach_set();
                    if (reach[tgt]) begin
                        st = ST_REACHABLE;
                    end else begin
                        alive[tgt] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            r.current_state    = cur;
            r.unreachable_mask = ~reach_set();
            r.present_mask     = alive;
            r.status           = st;
            pending.push_back(r);
        endfunction

        task report(string what, int got, int want);
            errors++;
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        endtask

        task check_result(logic [23:0] data);
            result_t want;
            if (pending.size() == 0) begin
                report("result beat with nothing expected", data, 0);
            end else begin
                want = pending.pop_front();
                if (data[2:0] != want.current_state)
                    report("current_state", data[2:0], want.current_state);
                if (data[10:3] != want.unreachable_mask)
                    report("unreachable_mask", data[10:3], want.unreachable_mask);
                if (data[18:11] != want.present_mask)
                    report("present_mask", data[18:11], want.present_mask);
                if (data[20:19] != want.status)
                    report("status", data[20:19], want.status);
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    fsm_scoreboard sb;
    int            cycles;
    bit            tx_idle;
    bit            rx_idle;
    bit            long_hold;

    programmable_fsm_with_reachability_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // The result side checks each beat and then decides m_tready for the next edge.
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (long_hold) begin
                long_hold = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 4) == 0) begin
                hold_left = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [2:0] req, input logic sym, input logic [2:0] tgt);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, tgt, sym};
        s_tuser  <= req;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(req, sym, tgt);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending.size() != 0);
    endtask

    // Deletions are permanent, so delete-all is held back until the last third of the run and delete-one stays rare.
    task automatic random_item(input int idx);
        int         pick;
        int         del_all_pct;
        int         del_one_pct;
        logic [2:0] req;
        del_all_pct = (idx < 2 * RANDOM_ITEMS / 3) ? 0 : 1;
        del_one_pct = (idx < RANDOM_ITEMS / 2) ? 2 : 6;
        pick = $urandom_range(0, 99);
        if (pick < del_all_pct)
            req = REQ_DEL_ALL;
        else if (pick < del_all_pct + del_one_pct)
            req = REQ_DEL_ONE;
        else if (pick < del_all_pct + del_one_pct + 3)
            req = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
        else if (pick < del_all_pct + del_one_pct + 13)
            req = REQ_QUERY;
        else if ($urandom_range(0, 1) == 0)
            req = REQ_STEP;
        else
            req = REQ_REDIRECT;
        send_item(req, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    endtask

    initial begin
        int mode;
        sb        = new();
        tx_idle   = 1'b1;
        rx_idle   = 1'b1;
        long_hold = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(REQ_QUERY, 1'b0, 3'd0);
        send_item(REQ_STEP, 1'b0, 3'd0);
        send_item(REQ_STEP, 1'b1, 3'd7);
        for (int c = REQ_SPARE_FIRST; c <= REQ_SPARE_LAST; c++)
            send_item(3'(c), 1'b1, 3'd7);
        // Both transitions of the current state point to itself, so all others fall away.
        send_item(REQ_REDIRECT, 1'b0, 3'd1);
        send_item(REQ_REDIRECT, 1'b1, 3'd1);
        send_item(REQ_QUERY, 1'b1, 3'd5);
        send_item(REQ_DEL_ONE, 1'b0, 3'd1);
        send_item(REQ_DEL_ONE, 1'b0, 3'd0);
        send_item(REQ_DEL_ONE, 1'b1, 3'd0);
        send_item(REQ_REDIRECT, 1'b1, 3'd0);
        send_item(REQ_REDIRECT, 1'b1, 3'd4);
        send_item(REQ_REDIRECT, 1'b0, 3'd7);
        send_item(REQ_STEP, 1'b1, 3'd0);
        send_item(REQ_DEL_ALL, 1'b0, 3'd0);
        send_item(REQ_STEP, 1'b0, 3'd7);
        send_item(REQ_QUERY, 1'b0, 3'd7);
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            mode    = (i / 150) % 4;
            tx_idle = (i < RANDOM_ITEMS - QUIET_ITEMS) && (mode == 1 || mode == 3);
            rx_idle = (i < RANDOM_ITEMS - QUIET_ITEMS) && (mode >= 2);
            if (i == 300)
                long_hold = 1'b1;
            if (i == 650)
                drain_results();
            random_item(i);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/pfr_pkg.sv
rtl/core/pfr_front.sv
rtl/core/pfr_queue.sv
rtl/core/pfr_back.sv
rtl/core/programmable_fsm_with_reachability_core.sv
tb/sv/tb_top.sv
